@@ rtl/core/bpra_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the page run allocator.
package bpra_pkg;

   // Free map geometry
   localparam int unsigned NUM_PAGES  = 1024;
   localparam int unsigned PAGE_SHIFT = 12;

   localparam int unsigned WORD_BITS  = (NUM_PAGES >= 32) ? 32 : (1 << $clog2(NUM_PAGES));
   localparam int unsigned NUM_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int unsigned BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int unsigned IDX_W      = WORD_IDX_W + BIT_IDX_W;
   localparam int unsigned MEM_ADDR_W = WORD_IDX_W + 1;
   localparam int unsigned MEM_DEPTH  = 1 << MEM_ADDR_W;
   localparam int unsigned PAGES_W    = $clog2(NUM_PAGES + 1);
   localparam int unsigned LEN_W      = BIT_IDX_W + 1;

   // Field widths
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned CNT_W      = 11;
   localparam int unsigned RUN_W      = CNT_W + 1;
   localparam int unsigned SUM_W      = ADDR_W + 1;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

   // Request codes
   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_FREE    = 1'b1;
   localparam logic POOL_KERNEL = 1'b0;
   localparam logic POOL_USER   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_BASE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_PAGES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_PAGES   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN      = 3'd4;

   // Register reset values
   localparam logic [CNT_W-1:0] PAGES_RESET   = 11'd1024;
   localparam logic [CNT_W-1:0] MAX_RUN_RESET = 11'd1023;

   typedef struct packed {
      logic                req_take;
      logic                scan_load;
      logic                scan_step;
      logic                upd_load;
      logic                upd_from_found;
      logic                upd_step;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_code;
   } bpra_cmd_type;

   typedef struct packed {
      logic alloc;
      logic req_bad;
      logic pool_empty;
      logic scan_hit;
      logic scan_miss;
      logic issue_done;
   } bpra_stat_type;

endpackage

@@ rtl/core/bpra_ctrl.sv @@
// Sequencing state machine of the page run allocator.
module bpra_ctrl import bpra_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  bpra_stat_type stat,
   output bpra_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_SCAN,
      ST_FOUND,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rsp_code = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_take = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.req_bad) begin
               code_in  = STATUS_BAD;
               state_in = ST_DONE;
            end else if (stat.alloc) begin
               if (stat.pool_empty) begin
                  code_in  = STATUS_NOFIT;
                  state_in = ST_DONE;
               end else begin
                  cmd.scan_load = 1'b1;
                  state_in      = ST_SCAN;
               end
            end else begin
               cmd.upd_load = 1'b1;
               code_in      = STATUS_OK;
               state_in     = ST_UPDATE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               state_in = ST_FOUND;
            end else if (stat.scan_miss) begin
               code_in  = STATUS_NOFIT;
               state_in = ST_DONE;
            end
         end
         ST_FOUND: begin
            cmd.upd_load       = 1'b1;
            cmd.upd_from_found = 1'b1;
            code_in            = STATUS_OK;
            state_in           = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd_step = 1'b1;
            if (stat.issue_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         code_ff      <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/bpra_dpath.sv @@
// Datapath: registers, free map memory, word scan pipeline and run update of the allocator.
module bpra_dpath import bpra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_action,
   input  logic                  req_pool_select,
   input  logic [CNT_W-1:0]      req_page_count,
   input  logic [ADDR_W-1:0]     req_address,
   input  bpra_cmd_type          cmd,
   output bpra_stat_type         stat,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_W-1:0]     rsp_run_address
);

   localparam int unsigned IDXF_W = ADDR_W - PAGE_SHIFT;

   // Configuration
   logic [ADDR_W-1:0] kernel_base_ff, user_base_ff;
   logic [CNT_W-1:0]  kernel_pages_ff, user_pages_ff, max_run_ff;

   // Request and decode
   logic              action_ff, pool_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [ADDR_W-1:0] base_in, base_ff;
   logic [CNT_W-1:0]  pages_sel;
   logic [PAGES_W-1:0] pages_eff_in, pages_eff_ff;
   logic              cnt_bad_in, cnt_bad_ff;
   logic              misalign_in, misalign_ff;
   logic              below_in, below_ff;
   logic [ADDR_W-1:0] diff_in, diff_ff;

   // Range check and run bounds
   logic [IDXF_W-1:0] free_idx;
   logic [SUM_W-1:0]  free_sum, free_hi_sum;
   logic              free_over;
   logic [IDX_W-1:0]  free_lo, free_hi, found_lo, lo_sel, hi_sel, last_idx;
   logic [IDX_W-1:0]  lo_ff, hi_ff;

   // Word walk and memory
   logic [WORD_IDX_W-1:0] w_ff, lim_ff, rd_w_ff, s1_w_ff;
   logic [BIT_IDX_W-1:0]  last_bit_ff;
   logic                  issue_done_ff, issue;
   logic                  rd_scan_ff, rd_upd_ff, rd_last_ff, rd_row_ok_ff;
   logic [WORD_BITS-1:0]  rd_data_ff, cur_word;
   logic [MEM_ADDR_W-1:0] rd_addr, wr_addr;
   logic [WORD_BITS-1:0]  mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]  row_valid_ff;
   logic [WORD_BITS-1:0]  lo_mask, hi_mask, upd_mask, wr_word;

   // Scan pipeline
   logic [WORD_BITS-1:0]  free_c;
   logic [LEN_W-1:0]      len_c [WORD_BITS];
   logic [WORD_BITS-1:0]  all_c;
   logic [LEN_W-1:0]      len_ff [WORD_BITS];
   logic [WORD_BITS-1:0]  all_ff;
   logic                  s1_valid_ff, s1_last_ff;
   logic [RUN_W-1:0]      run_c [WORD_BITS];
   logic [WORD_BITS-1:0]  hit_c;
   logic                  any_hit, s2_fire;
   logic [BIT_IDX_W-1:0]  first_p;
   logic [RUN_W-1:0]      run_ff;
   logic                  hit_ff, miss_ff;
   logic [IDX_W-1:0]      run_end_ff;

   // Result
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_run_address_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_base_ff  <= '0;
         user_base_ff    <= '0;
         kernel_pages_ff <= PAGES_RESET;
         user_pages_ff   <= PAGES_RESET;
         max_run_ff      <= MAX_RUN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KERNEL_BASE:  kernel_base_ff  <= csr_wdata;
            CSR_USER_BASE:    user_base_ff    <= csr_wdata;
            CSR_KERNEL_PAGES: kernel_pages_ff <= csr_wdata[CNT_W-1:0];
            CSR_USER_PAGES:   user_pages_ff   <= csr_wdata[CNT_W-1:0];
            CSR_MAX_RUN:      max_run_ff      <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         action_ff  <= req_action;
         pool_ff    <= req_pool_select;
         count_ff   <= req_page_count;
         address_ff <= req_address;
      end
   end

   // Decode stage: pool selection, clamp, count and alignment checks
   always_comb begin
      base_in   = (pool_ff == POOL_USER) ? user_base_ff : kernel_base_ff;
      pages_sel = (pool_ff == POOL_USER) ? user_pages_ff : kernel_pages_ff;
      pages_eff_in = (32'(pages_sel) > 32'(NUM_PAGES)) ? PAGES_W'(NUM_PAGES)
                                                      : PAGES_W'(pages_sel);
      cnt_bad_in  = (count_ff == '0) || (count_ff > max_run_ff);
      misalign_in = (address_ff[PAGE_SHIFT-1:0] != '0);
      {below_in, diff_in} = {1'b0, address_ff} - {1'b0, base_in};
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      pages_eff_ff <= pages_eff_in;
      cnt_bad_ff   <= cnt_bad_in;
      misalign_ff  <= misalign_in;
      below_ff     <= below_in;
      diff_ff      <= diff_in;
   end

   // Check stage: free range against the pool, run bounds
   always_comb begin
      free_idx    = diff_ff[ADDR_W-1:PAGE_SHIFT];
      free_sum    = SUM_W'(free_idx) + SUM_W'(count_ff);
      free_hi_sum = free_sum - SUM_W'(1);
      free_over   = (free_sum > SUM_W'(pages_eff_ff));
      free_lo     = IDX_W'(free_idx);
      free_hi     = free_hi_sum[IDX_W-1:0];
      found_lo    = IDX_W'(SUM_W'(run_end_ff) + SUM_W'(1) - SUM_W'(count_ff));
      lo_sel      = cmd.upd_from_found ? found_lo : free_lo;
      hi_sel      = cmd.upd_from_found ? run_end_ff : free_hi;
      last_idx    = IDX_W'(pages_eff_ff - PAGES_W'(1));
   end

   assign stat.alloc      = (action_ff == ACT_ALLOC);
   assign stat.req_bad    = cnt_bad_ff ||
                            ((action_ff == ACT_FREE) && (misalign_ff || below_ff || free_over));
   assign stat.pool_empty = (pages_eff_ff == '0);
   assign stat.scan_hit   = hit_ff;
   assign stat.scan_miss  = miss_ff;
   assign stat.issue_done = issue_done_ff;

   // Word walk: one map word read per step
   assign issue   = (cmd.scan_step || cmd.upd_step) && !issue_done_ff;
   assign rd_addr = {pool_ff, w_ff};
   assign wr_addr = {pool_ff, rd_w_ff};

   always_ff @(posedge clock) begin
      if (cmd.scan_load) begin
         w_ff        <= '0;
         lim_ff      <= last_idx[IDX_W-1:BIT_IDX_W];
         last_bit_ff <= last_idx[BIT_IDX_W-1:0];
      end else if (cmd.upd_load) begin
         w_ff   <= lo_sel[IDX_W-1:BIT_IDX_W];
         lim_ff <= hi_sel[IDX_W-1:BIT_IDX_W];
         lo_ff  <= lo_sel;
         hi_ff  <= hi_sel;
      end else if (issue) begin
         w_ff <= w_ff + 1'b1;
      end
      if (issue) begin
         rd_w_ff    <= w_ff;
         rd_last_ff <= (w_ff == lim_ff);
      end
   end

   // Map memory, one read and one write port
   always_ff @(posedge clock) begin
      if (rd_upd_ff) begin
         mem[wr_addr] <= wr_word;
      end
      if (issue) begin
         rd_data_ff   <= mem[rd_addr];
         rd_row_ok_ff <= row_valid_ff[rd_addr];
      end
   end

   // A row never written since reset reads as all free
   assign cur_word = rd_row_ok_ff ? rd_data_ff : '0;

   // Read-modify-write of one word of the run
   always_comb begin
      lo_mask  = (rd_w_ff == lo_ff[IDX_W-1:BIT_IDX_W]) ?
                 ({WORD_BITS{1'b1}} << lo_ff[BIT_IDX_W-1:0]) : {WORD_BITS{1'b1}};
      hi_mask  = (rd_w_ff == hi_ff[IDX_W-1:BIT_IDX_W]) ?
                 ({WORD_BITS{1'b1}} >> (~hi_ff[BIT_IDX_W-1:0])) : {WORD_BITS{1'b1}};
      upd_mask = lo_mask & hi_mask;
      wr_word  = (action_ff == ACT_ALLOC) ? (cur_word | upd_mask) : (cur_word & ~upd_mask);
   end

   // Scan stage 1: free bits, then free-run length ending at each bit
   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         free_c[p] = !cur_word[p] && (!rd_last_ff || (BIT_IDX_W'(p) <= last_bit_ff));
         len_c[p]  = LEN_W'(free_c[p]);
      end
      all_c = free_c;
      for (int s = 1; s < WORD_BITS; s = s * 2) begin
         for (int p = WORD_BITS - 1; p >= s; p--) begin
            if (all_c[p]) begin
               len_c[p] = len_c[p] + len_c[p - s];
               all_c[p] = all_c[p - s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_c;
      all_ff     <= all_c;
      s1_w_ff    <= rd_w_ff;
      s1_last_ff <= rd_last_ff;
   end

   // Scan stage 2: join the carried run, find the first bit that closes a fit
   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         run_c[p] = all_ff[p] ? (run_ff + RUN_W'(len_ff[p])) : RUN_W'(len_ff[p]);
         hit_c[p] = (run_c[p] >= RUN_W'(count_ff));
      end
      any_hit = |hit_c;
      first_p = '0;
      for (int p = WORD_BITS - 1; p >= 0; p--) begin
         if (hit_c[p]) begin
            first_p = BIT_IDX_W'(p);
         end
      end
   end

   assign s2_fire = s1_valid_ff && !hit_ff && !miss_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_load) begin
         run_ff <= '0;
      end else if (s2_fire && !any_hit) begin
         run_ff <= run_c[WORD_BITS-1];
      end
      if (s2_fire && any_hit) begin
         run_end_ff <= {s1_w_ff, first_p};
      end
   end

   // Control flags of walk and pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_done_ff <= 1'b0;
         rd_scan_ff    <= 1'b0;
         rd_upd_ff     <= 1'b0;
         s1_valid_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         miss_ff       <= 1'b0;
         row_valid_ff  <= '0;
      end else begin
         if (cmd.scan_load || cmd.upd_load) begin
            issue_done_ff <= 1'b0;
         end else if (issue && (w_ff == lim_ff)) begin
            issue_done_ff <= 1'b1;
         end
         rd_scan_ff  <= issue && cmd.scan_step;
         rd_upd_ff   <= issue && cmd.upd_step;
         s1_valid_ff <= rd_scan_ff && !cmd.scan_load;
         if (cmd.scan_load) begin
            hit_ff  <= 1'b0;
            miss_ff <= 1'b0;
         end else if (s2_fire) begin
            if (any_hit) begin
               hit_ff <= 1'b1;
            end else if (s1_last_ff) begin
               miss_ff <= 1'b1;
            end
         end
         if (rd_upd_ff) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff      <= cmd.rsp_code;
         rsp_run_address_ff <= ((cmd.rsp_code == STATUS_OK) && (action_ff == ACT_ALLOC)) ?
                               (base_ff + (ADDR_W'(lo_ff) << PAGE_SHIFT)) : '0;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_run_address = rsp_run_address_ff;

   a_hit_miss_excl: assert property (@(posedge clock) disable iff (reset)
      !(hit_ff && miss_ff))
      else $error("scan reports both a fit and no fit");

   a_rmw_no_collide: assert property (@(posedge clock) disable iff (reset)
      (rd_upd_ff && issue) |-> (rd_w_ff != w_ff))
      else $error("map read and write hit the same word");

   a_run_below_count: assert property (@(posedge clock) disable iff (reset)
      s2_fire |-> (run_ff < RUN_W'(count_ff)))
      else $error("carried free run already covers the request");

endmodule

@@ rtl/core/bitmap_page_run_allocator.sv @@
// Top level of the two-pool first-fit page run allocator.
// Sequence: a bad request answers after decode and check; a free rewrites m map words, and an
// allocate scans k map words and then rewrites m map words of the found run
// (one word per cycle through the map memory port).
// Throughput: one request at a time; the next beat is taken while a result waits.
// Reset: synchronous; maps read as all free (per-row valid bits), registers take reset values.
module bitmap_page_run_allocator import bpra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic                  req_pool_select,
   input  logic [CNT_W-1:0]      req_page_count,
   input  logic [ADDR_W-1:0]     req_address,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_W-1:0]     rsp_run_address
);

   bpra_cmd_type  cmd;
   bpra_stat_type stat;

   // Controller: decode, check, scan, mark or clear, then hold the result beat
   bpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: registers, map memory, word scan pipeline, run update
   bpra_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_action),
      .req_pool_select (req_pool_select),
      .req_page_count  (req_page_count),
      .req_address     (req_address),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_run_address (rsp_run_address)
   );

endmodule
